### sv/piecewise_linear_ramp_lookup_macros.svh
// Assertion macros for the piecewise linear ramp lookup.
// Included by the top level; no other dependencies.
`ifndef PIECEWISE_LINEAR_RAMP_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_RAMP_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/plr_pkg.sv
// Shared types and constants for the piecewise linear ramp lookup.
// No dependencies.
`default_nettype none
package plr_pkg;

	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 20;
	localparam int IDX_W   = 5;
	localparam int QUOT_W  = 20;
	localparam int DCNT_W  = 5;
	localparam int PROD_W  = QUOT_W + TIME_W;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic signed [LEVEL_W-1:0] FULL_LEVEL = 20'sd65536;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX  = 20'sd262143 + 20'sd262144;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN  = -20'sd262144 - 20'sd262144;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [IDX_W-1:0]          entry_index;
		logic [TIME_W-1:0]         entry_time;
		logic signed [LEVEL_W-1:0] entry_level;
		logic [TIME_W-1:0]         query_time;
	} in_item_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic                      in_ramp;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_QUERY,
		CMD_DEFAULT
	} cmd_t;

	// One classified operation between front and back
	typedef struct packed {
		cmd_t                      cmd;
		logic [IDX_W-1:0]          idx;
		logic [TIME_W-1:0]         tm;
		logic signed [LEVEL_W-1:0] lvl;
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_MUL,
		BK_DIV,
		BK_FIN,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

### sv/plr_front.sv
// Front end: accepts input items, classifies them and registers them for the queue.
// Depends on plr_pkg.
`default_nettype none
module plr_front import plr_pkg::*; #(
	parameter int RAMP_POINTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire in_item_t          item,
	input  wire logic [TIME_W-1:0] start_time,
	input  wire logic              q_full,
	output logic                   q_push,
	output op_t                    q_op
);

	logic valid_s1;
	op_t  op_s1;
	logic keep;
	op_t  op_nxt;

	// Classify: drop writes beyond the table, mark queries before start
	always_comb begin
		op_nxt     = '0;
		op_nxt.idx = item.entry_index;
		op_nxt.lvl = item.entry_level;
		keep       = 1'b1;
		if (item.action == ACT_WRITE) begin
			op_nxt.cmd = CMD_WRITE;
			op_nxt.tm  = item.entry_time;
			keep       = {27'd0, item.entry_index} < 32'(RAMP_POINTS);
		end else if (item.query_time < start_time) begin
			op_nxt.cmd = CMD_DEFAULT;
			op_nxt.tm  = item.query_time;
		end else begin
			op_nxt.cmd = CMD_QUERY;
			op_nxt.tm  = item.query_time - start_time;
		end
	end

	assign item_stall = valid_s1 & q_full;
	assign q_push     = valid_s1 & ~q_full;
	assign q_op       = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1 <= op_nxt;
		end
	end

endmodule
`default_nettype wire

### sv/plr_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on plr_pkg.
`default_nettype none
module plr_queue import plr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	output logic      head_valid,
	output op_t       head,
	input  wire logic pop
);

	op_t                ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full       = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

endmodule
`default_nettype wire

### sv/plr_back.sv
// Back end: breakpoint table, sequential search, interpolation and result register.
// Depends on plr_pkg.
`default_nettype none
module plr_back import plr_pkg::*; #(
	parameter int RAMP_POINTS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire op_t  head,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output out_item_t result
);

	localparam int AW = $clog2(RAMP_POINTS);

	// Table memory
	logic [TIME_W-1:0]         tmem [RAMP_POINTS];
	logic signed [LEVEL_W-1:0] lmem [RAMP_POINTS];
	logic [TIME_W-1:0]         rd_t_q;
	logic signed [LEVEL_W-1:0] rd_l_q;
	logic                      wr_en;
	logic [AW-1:0]             rd_addr;

	back_state_t state_q, state_nxt;

	logic [TIME_W-1:0]         elapsed_q;
	logic [AW-1:0]             cnt_q;
	logic [TIME_W-1:0]         prev_t_q;
	logic signed [LEVEL_W-1:0] prev_l_q;
	logic                      neg_q;
	logic [QUOT_W-1:0]         mag_q;
	logic [TIME_W-1:0]         de_q;
	logic [TIME_W-1:0]         dt_q;
	logic [TIME_W-1:0]         rem_q;
	logic [QUOT_W-1:0]         nq_q;
	logic [DCNT_W-1:0]         div_cnt_q;
	out_item_t                 res_q;
	logic                      out_valid_q;
	out_item_t                 out_q;

	logic                      hit, first, last, out_free, out_load;
	logic signed [LEVEL_W:0]   dp;
	logic [LEVEL_W:0]          dp_abs;
	logic [PROD_W-1:0]         prod;
	logic [TIME_W+1:0]         trial;
	logic                      ge;
	logic signed [LEVEL_W+1:0] sq, sum;
	logic signed [LEVEL_W-1:0] sat;

	assign hit      = elapsed_q < rd_t_q;
	assign first    = cnt_q == '0;
	assign last     = cnt_q == AW'(RAMP_POINTS - 1);
	assign out_free = ~out_valid_q | ~result_stall;

	assign dp     = {rd_l_q[LEVEL_W-1], rd_l_q} - {prev_l_q[LEVEL_W-1], prev_l_q};
	assign dp_abs = dp[LEVEL_W] ? (LEVEL_W+1)'(1) + ~dp : dp;
	assign prod   = {{TIME_W{1'b0}}, mag_q} * {{QUOT_W{1'b0}}, de_q};

	// Restoring divide step: shift in the next numerator bit, try the subtract
	assign trial = {1'b0, rem_q, nq_q[QUOT_W-1]} - {2'b00, dt_q};
	assign ge    = ~trial[TIME_W+1];

	assign sq  = neg_q ? -$signed({2'b00, nq_q}) : $signed({2'b00, nq_q});
	assign sum = {{2{prev_l_q[LEVEL_W-1]}}, prev_l_q} + sq;
	always_comb begin
		if (sum > (LEVEL_W+2)'(LEVEL_MAX)) begin
			sat = LEVEL_MAX;
		end else if (sum < (LEVEL_W+2)'(LEVEL_MIN)) begin
			sat = LEVEL_MIN;
		end else begin
			sat = sum[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		wr_en     = 1'b0;
		out_load  = 1'b0;
		rd_addr   = cnt_q + AW'(1);
		case (state_q)
			BK_IDLE: begin
				rd_addr = '0;
				if (head_valid) begin
					pop = 1'b1;
					case (head.cmd)
						CMD_WRITE:   wr_en = 1'b1;
						CMD_QUERY:   state_nxt = BK_SCAN;
						CMD_DEFAULT: state_nxt = BK_EMIT;
						default:     state_nxt = BK_IDLE;
					endcase
				end
			end
			BK_SCAN: begin
				if (hit) begin
					state_nxt = first ? BK_EMIT : BK_MUL;
				end else if (last) begin
					state_nxt = BK_EMIT;
				end
			end
			BK_MUL: state_nxt = BK_DIV;
			BK_DIV: begin
				if (div_cnt_q == DCNT_W'(QUOT_W - 1)) begin
					state_nxt = BK_FIN;
				end
			end
			BK_FIN: state_nxt = BK_EMIT;
			BK_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmem[AW'(head.idx)] <= head.tm;
			lmem[AW'(head.idx)] <= head.lvl;
		end
		rd_t_q <= tmem[rd_addr];
		rd_l_q <= lmem[rd_addr];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				elapsed_q <= head.tm;
				cnt_q     <= '0;
				res_q     <= '{level: FULL_LEVEL, in_ramp: 1'b0};
			end
			BK_SCAN: begin
				cnt_q    <= cnt_q + AW'(1);
				// Keep the breakpoint before the hit for the interpolation base
				if (!hit) begin
					prev_t_q <= rd_t_q;
					prev_l_q <= rd_l_q;
				end
				neg_q    <= dp[LEVEL_W];
				mag_q    <= dp_abs[QUOT_W-1:0];
				de_q     <= elapsed_q - prev_t_q;
				dt_q     <= rd_t_q - prev_t_q;
				if (hit && first) begin
					res_q <= '{level: rd_l_q, in_ramp: 1'b1};
				end
			end
			BK_MUL: begin
				// Quotient fits QUOT_W bits, so the upper product bits start below dt
				rem_q     <= prod[PROD_W-1:QUOT_W];
				nq_q      <= prod[QUOT_W-1:0];
				div_cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q     <= ge ? trial[TIME_W-1:0] : {rem_q[TIME_W-2:0], nq_q[QUOT_W-1]};
				nq_q      <= {nq_q[QUOT_W-2:0], ge};
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
			BK_FIN: begin
				res_q <= '{level: sat, in_ramp: 1'b1};
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

### sv/piecewise_linear_ramp_lookup.sv
// Piecewise linear ramp lookup: top level joining front end, queue and back end.
// Depends on plr_pkg, plr_front, plr_queue, plr_back and the assertion macro header.
//
// Use: the item channel (item_valid / item_stall / item) carries writes and queries.
// A write (action 0) loads one breakpoint, time and level, into slot entry_index and
// gives no result; a slot at or beyond RAMP_POINTS is dropped. A query (action 1)
// gives one transfer on the result channel (result_valid / result_stall / result): full
// level 1.0 with in_ramp low before start_time or past the last breakpoint, slot 0's
// level before slot 0, else the level interpolated between the neighbouring breakpoints.
// start_time is written over the cfg channel (cfg_valid / cfg_ready / cfg_data),
// always ready; write it only while no query is in flight.
// From the item transfer to the output register load, an item passes the front stage
// register and the queue and is popped; a query then searches the table one entry a
// cycle until a hit, multiplies, divides one quotient bit a cycle, adds the base
// level, saturates and loads the output register. A hit at slot 0, a query before
// start and one past the last breakpoint go straight to the output register. Writes
// retire one a cycle while the back end is idle. The back end handles one query at a
// time; the 4-deep queue lets the front keep accepting meanwhile. Reset clears control
// state and start_time; the table is undefined until written. When the receiver
// stalls, the result holds, the back end waits, the queue fills and item_stall rises.
`default_nettype none
`include "piecewise_linear_ramp_lookup_macros.svh"
module piecewise_linear_ramp_lookup import plr_pkg::*; #(
	parameter int RAMP_POINTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire in_item_t          item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output out_item_t              result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [TIME_W-1:0] cfg_data
);

	logic [TIME_W-1:0] start_time_q;
	logic              q_push, q_full, q_valid, q_pop;
	op_t               q_in, q_head;

	// Config register: the ramp start, taken on every cfg transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_time_q <= cfg_data;
		end
	end

	// Front end: classify and hold one item for the queue
	plr_front #(
		.RAMP_POINTS(RAMP_POINTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.start_time(start_time_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (q_in)
	);

	// Decouple front from back so each can stall on its own
	plr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (q_in),
		.full      (q_full),
		.head_valid(q_valid),
		.head      (q_head),
		.pop       (q_pop)
	);

	// Back end: table, search, interpolation and output register
	plr_back #(
		.RAMP_POINTS(RAMP_POINTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_valid),
		.head        (q_head),
		.pop         (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// A default answer always carries the full level
	`PLR_ASSERT_IMPLY(a_default_full, clk, arst_n, result_valid && !result.in_ramp, result.level == FULL_LEVEL, "default result not at full level")
	// Never push into a full queue
	`PLR_ASSERT_IMPLY(a_no_overflow, clk, arst_n, q_push, !q_full, "queue overflow")
	// Never pop an empty queue
	`PLR_ASSERT_IMPLY(a_no_underflow, clk, arst_n, q_pop, q_valid, "queue underflow")
	// A push without a pop into a non-empty queue leaves it holding entries
	`PLR_ASSERT_NEXT(a_push_leaves_room, clk, arst_n, q_push && !q_pop && q_valid, q_valid, "queue lost entries")

endmodule
`default_nettype wire
